/* sv/crfpl_pkg.sv */
`timescale 1ns / 1ps

package crfpl_pkg;

  localparam int unsigned MAX_DIMS     = 8;
  localparam int unsigned DIM_W        = 3;
  localparam int unsigned MAX_FEATURES = 64;
  localparam int unsigned FEAT_W       = 6;
  localparam int unsigned NUM_LEVELS   = 4;
  localparam int unsigned NUM_PAIRS    = 28;
  localparam int unsigned PAIR_W       = 5;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned VAL_W        = 24;
  localparam int unsigned PROB_W       = 17;
  localparam int unsigned OPND_W       = 25;
  localparam int unsigned PROD_W       = 2 * OPND_W;
  localparam int unsigned ACC_W        = 40;

  localparam logic [PROB_W-1:0] ONE_FX = PROB_W'(1 << FRAC_BITS);

  // Operation codes of an input word
  typedef enum logic [2:0] {
    OP_BIAS    = 3'd0,
    OP_FWEIGHT = 3'd1,
    OP_PWEIGHT = 3'd2,
    OP_OEMIS   = 3'd3,
    OP_IEMIS   = 3'd4,
    OP_FEATURE = 3'd5,
    OP_POST    = 3'd6,
    OP_COMPUTE = 3'd7
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_DIMS     = 2'd0,
    CFG_NUM_FEATURES = 2'd1,
    CFG_EDGE_MASK    = 2'd2,
    CFG_USE_EMISSION = 2'd3
  } cfg_e;

  // Second dimension of pair number b in upper-triangle order
  function automatic logic [DIM_W:0] pair_second_dim(input int unsigned b);
    int unsigned n;
    logic [DIM_W:0] r;
    n = 0;
    r = '0;
    for (int unsigned i = 0; i < MAX_DIMS; i++) begin
      for (int unsigned j = i + 1; j < MAX_DIMS; j++) begin
        if (n == b) r = (DIM_W+1)'(j);
        n++;
      end
    end
    return r;
  endfunction

  // Piecewise linear sigmoid on a saturated Q8.16 input
  function automatic logic [PROB_W-1:0] sigmoid_fx(input logic signed [VAL_W-1:0] z);
    logic [VAL_W-1:0] a;
    logic [VAL_W:0]   y;
    a = z[VAL_W-1] ? VAL_W'(-z) : VAL_W'(z);
    if (a >= VAL_W'(327680)) begin
      y = (VAL_W+1)'(ONE_FX);
    end else if (a >= VAL_W'(155648)) begin
      y = (VAL_W+1)'(a >> 5) + (VAL_W+1)'(55296);
    end else if (a >= VAL_W'(65536)) begin
      y = (VAL_W+1)'(a >> 3) + (VAL_W+1)'(40960);
    end else begin
      y = (VAL_W+1)'(a >> 2) + (VAL_W+1)'(32768);
    end
    if (y > (VAL_W+1)'(ONE_FX)) y = (VAL_W+1)'(ONE_FX);
    return z[VAL_W-1] ? (ONE_FX - y[PROB_W-1:0]) : y[PROB_W-1:0];
  endfunction

endpackage

/* sv/crfpl_mac.sv */
`timescale 1ns / 1ps

module crfpl_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [crfpl_pkg::OPND_W-1:0]   a_i,
  input  logic signed [crfpl_pkg::OPND_W-1:0]   b_i,
  output logic                                  valid_o,
  output logic signed [crfpl_pkg::PROD_W-1:0]   prod_o
);

  logic                                valid_q;
  logic signed [crfpl_pkg::PROD_W-1:0] prod_q;

  // Register the valid flag of the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Multiply and hold the full product
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= crfpl_pkg::PROD_W'(a_i) * crfpl_pkg::PROD_W'(b_i);
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

/* sv/crf_pseudolikelihood_marginals.sv */
`timescale 1ns / 1ps

// Load words (operations 0 to 6) are taken one per cycle while busy is low. A
// compute word runs one shared 25x25 multiplier under a sequencer and holds
// busy high while it runs: each dimension streams one feature product per
// cycle, sweeps all 28 pair slots once, drains the multiplier, then
// saturates and applies the sigmoid; the pair pass sweeps the 28 slots again
// and each connected pair takes two products. Results appear on out_valid_o
// for exactly one cycle each and cannot be stalled: marginals in dimension
// order, then pair words, with last_o on the final one. Store entries never
// written read as anything.
module crf_pseudolikelihood_marginals (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [27:0]                         cfg_data_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          operation_i,
  input  logic [5:0]                          index_a_i,
  input  logic [2:0]                          index_b_i,
  input  logic signed [crfpl_pkg::VAL_W-1:0]  value_i,
  input  logic [2:0]                          category_i,
  output logic                                out_valid_o,
  output logic                                kind_o,
  output logic [4:0]                          index_o,
  output logic [crfpl_pkg::PROB_W-1:0]        probability_o,
  output logic [crfpl_pkg::PROB_W-1:0]        pair_first_o,
  output logic [crfpl_pkg::PROB_W-1:0]        pair_second_o,
  output logic                                last_o
);

  localparam int unsigned DW = crfpl_pkg::DIM_W;
  localparam int unsigned VW = crfpl_pkg::VAL_W;
  localparam int unsigned PW = crfpl_pkg::PROB_W;
  localparam int unsigned AW = crfpl_pkg::ACC_W;
  localparam int unsigned NP = crfpl_pkg::NUM_PAIRS;
  localparam int unsigned FEAT_AW = crfpl_pkg::FEAT_W;
  localparam int unsigned FRAC_HI = crfpl_pkg::FRAC_BITS + PW - 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FEAT  = 3'd1;
  localparam logic [2:0] ST_PAIRS = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_SIG   = 3'd5;
  localparam logic [2:0] ST_OUTP  = 3'd6;
  localparam logic [2:0] ST_ODRN  = 3'd7;

  localparam logic [1:0] TAG_FEAT = 2'd0;
  localparam logic [1:0] TAG_PW   = 2'd1;
  localparam logic [1:0] TAG_PF   = 2'd2;
  localparam logic [1:0] TAG_PS   = 2'd3;

  localparam logic [DW-1:0] LAST_DIM = DW'(crfpl_pkg::MAX_DIMS - 1);

  // Configuration registers
  logic [3:0]  num_dims_q;
  logic [6:0]  num_feat_q;
  logic [27:0] edge_mask_q;
  logic        use_emis_q;

  // Model stores
  logic signed [VW-1:0] bias_q   [crfpl_pkg::MAX_DIMS];
  logic signed [VW-1:0] fw_mem   [crfpl_pkg::MAX_FEATURES * crfpl_pkg::MAX_DIMS];
  logic signed [VW-1:0] pw_q     [NP];
  logic signed [VW-1:0] oe_q     [crfpl_pkg::MAX_DIMS * crfpl_pkg::NUM_LEVELS];
  logic signed [VW-1:0] ie_q     [crfpl_pkg::MAX_DIMS * crfpl_pkg::NUM_LEVELS];
  logic signed [VW-1:0] feat_mem [crfpl_pkg::MAX_FEATURES];
  logic [PW-1:0]        post_q   [crfpl_pkg::MAX_DIMS];
  logic [2:0]           level_q  [crfpl_pkg::MAX_DIMS];
  logic [PW-1:0]        marg_q   [crfpl_pkg::MAX_DIMS];

  // Sequencer state
  logic [2:0]    state_q;
  logic [DW-1:0] d_q, i_q, j_q;
  logic [6:0]    f_q;
  logic [4:0]    bit_q, c_q;
  logic          sub_q;
  logic signed [AW-1:0] acc_q;
  logic signed [VW-1:0] z_q;
  logic [PW-1:0] pf_q;

  // Pipeline
  logic          v1_q, v2_q;
  logic [1:0]    tag1_q, tag2_q;
  logic [4:0]    idx1_q, idx2_q;
  logic          last1_q, last2_q;
  logic signed [VW-1:0] fw_rd_q, ft_rd_q, pw_rd_q;
  logic [PW-1:0] post_rd_q, marg_rd_q;
  logic signed [crfpl_pkg::PROD_W-1:0] prod;
  logic          mac_v;

  // Output registers
  logic          out_valid_q, kind_q, last_q;
  logic [4:0]    index_q;
  logic [PW-1:0] prob_q, pfirst_q, psecond_q;

  // Combinational control
  logic [DW:0]   nd;
  logic [6:0]    nf;
  logic [NP-1:0] eff_mask;
  logic [NP-1:0] above_mask;
  logic          any_pair, rest_pairs, conn, touches;
  logic          iss_v;
  logic [1:0]    iss_tag;
  logic [DW-1:0] post_addr, marg_addr, other;
  logic [8:0]    fw_addr;
  logic [FEAT_AW-1:0] ft_addr;
  logic signed [crfpl_pkg::OPND_W-1:0] opa, opb;
  logic [4:0]    lv_addr;
  logic signed [AW-1:0] zsum;
  logic          accept;
  logic [DW-1:0] ia_dim;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign ia_dim = index_a_i[DW-1:0];

  // Clamp the dimension and feature counts
  always_comb begin
    if (num_dims_q == 4'd0) nd = (DW+1)'(1);
    else if (num_dims_q > 4'(crfpl_pkg::MAX_DIMS)) nd = (DW+1)'(crfpl_pkg::MAX_DIMS);
    else nd = num_dims_q;
    nf = (num_feat_q > 7'(crfpl_pkg::MAX_FEATURES)) ? 7'(crfpl_pkg::MAX_FEATURES) : num_feat_q;
  end

  // Mark pairs that are connected and lie within the active dimensions
  always_comb begin
    for (int unsigned b = 0; b < NP; b++) begin
      eff_mask[b]   = edge_mask_q[b] && (crfpl_pkg::pair_second_dim(b) < nd);
      above_mask[b] = (5'(b) > bit_q);
    end
  end

  assign any_pair   = |eff_mask;
  assign rest_pairs = |(eff_mask & above_mask);
  assign conn       = eff_mask[bit_q];
  assign touches    = (i_q == d_q) || (j_q == d_q);
  assign other      = (i_q == d_q) ? j_q : i_q;

  // Issue one multiply per cycle from the sequencer
  always_comb begin
    iss_v     = 1'b0;
    iss_tag   = TAG_FEAT;
    post_addr = other;
    marg_addr = i_q;
    unique case (state_q)
      ST_FEAT: begin
        iss_v = (f_q < nf);
      end
      ST_PAIRS: begin
        iss_v   = conn && touches;
        iss_tag = TAG_PW;
      end
      ST_OUTP: begin
        iss_v     = conn;
        iss_tag   = sub_q ? TAG_PS : TAG_PF;
        post_addr = sub_q ? i_q : j_q;
        marg_addr = sub_q ? j_q : i_q;
      end
      default: begin
        iss_v = 1'b0;
      end
    endcase
  end

  assign fw_addr = {f_q[FEAT_AW-1:0], d_q};
  assign ft_addr = f_q[FEAT_AW-1:0];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q  <= 4'd8;
      num_feat_q  <= 7'd64;
      edge_mask_q <= 28'hFFFFFFF;
      use_emis_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crfpl_pkg::CFG_NUM_DIMS:     num_dims_q  <= cfg_data_i[3:0];
        crfpl_pkg::CFG_NUM_FEATURES: num_feat_q  <= cfg_data_i[6:0];
        crfpl_pkg::CFG_EDGE_MASK:    edge_mask_q <= cfg_data_i;
        crfpl_pkg::CFG_USE_EMISSION: use_emis_q  <= cfg_data_i[0];
        default: use_emis_q <= use_emis_q;
      endcase
    end
  end

  // Load words into the stores; registered reads feed the multiplier
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unique case (operation_i)
        crfpl_pkg::OP_BIAS: begin
          if (index_a_i[5:DW] == '0) bias_q[ia_dim] <= value_i;
        end
        crfpl_pkg::OP_FWEIGHT: begin
          fw_mem[{index_a_i, index_b_i}] <= value_i;
        end
        crfpl_pkg::OP_PWEIGHT: begin
          if (index_a_i < 6'(NP)) pw_q[index_a_i[4:0]] <= value_i;
        end
        crfpl_pkg::OP_OEMIS: begin
          if (index_a_i[5:DW] == '0 && index_b_i >= 3'd1 && index_b_i <= 3'd4)
            oe_q[{ia_dim, 2'(index_b_i - 3'd1)}] <= value_i;
        end
        crfpl_pkg::OP_IEMIS: begin
          if (index_a_i[5:DW] == '0 && index_b_i >= 3'd1 && index_b_i <= 3'd4)
            ie_q[{ia_dim, 2'(index_b_i - 3'd1)}] <= value_i;
        end
        crfpl_pkg::OP_FEATURE: begin
          feat_mem[index_a_i] <= value_i;
        end
        crfpl_pkg::OP_POST: begin
          if (index_a_i[5:DW] == '0) begin
            if (value_i < 0) post_q[ia_dim] <= '0;
            else if (value_i > VW'(signed'({1'b0, crfpl_pkg::ONE_FX})))
              post_q[ia_dim] <= crfpl_pkg::ONE_FX;
            else post_q[ia_dim] <= value_i[PW-1:0];
            level_q[ia_dim] <= (category_i >= 3'd1 && category_i <= 3'd4) ? category_i : 3'd0;
          end
        end
        default: begin
          post_q[0] <= post_q[0];
        end
      endcase
    end
    if (state_q == ST_SIG) marg_q[d_q] <= crfpl_pkg::sigmoid_fx(z_q);
    fw_rd_q   <= fw_mem[fw_addr];
    ft_rd_q   <= feat_mem[ft_addr];
    pw_rd_q   <= pw_q[c_q];
    post_rd_q <= post_q[post_addr];
    marg_rd_q <= marg_q[marg_addr];
  end

  // Pick operands for the shared multiplier
  always_comb begin
    case (tag1_q)
      TAG_FEAT: begin
        opa = crfpl_pkg::OPND_W'(ft_rd_q);
        opb = crfpl_pkg::OPND_W'(fw_rd_q);
      end
      TAG_PW: begin
        opa = crfpl_pkg::OPND_W'(pw_rd_q);
        opb = signed'({8'd0, post_rd_q});
      end
      default: begin
        opa = signed'({8'd0, marg_rd_q});
        opb = signed'({8'd0, post_rd_q});
      end
    endcase
  end

  crfpl_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .a_i     (opa),
    .b_i     (opb),
    .valid_o (mac_v),
    .prod_o  (prod)
  );

  // Emission terms added to the accumulated z
  assign lv_addr = {d_q, 2'(level_q[d_q] - 3'd1)};
  always_comb begin
    zsum = acc_q;
    if (use_emis_q && level_q[d_q] != 3'd0)
      zsum = acc_q + AW'(oe_q[lv_addr]) - AW'(ie_q[lv_addr]);
  end

  // Pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= iss_v;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q  <= iss_tag;
    idx1_q  <= c_q;
    last1_q <= !rest_pairs;
    tag2_q  <= tag1_q;
    idx2_q  <= idx1_q;
    last2_q <= last1_q;
  end

  // Sequencer, accumulator and result words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      d_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      f_q         <= '0;
      bit_q       <= '0;
      c_q         <= '0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (state_q == ST_SIG) || (mac_v && tag2_q == TAG_PS);
      unique case (state_q)
        ST_IDLE: begin
          if (accept && operation_i == crfpl_pkg::OP_COMPUTE) begin
            d_q     <= '0;
            f_q     <= '0;
            state_q <= ST_FEAT;
          end
        end
        ST_FEAT: begin
          if (f_q < nf) begin
            f_q <= f_q + 7'd1;
          end else begin
            bit_q   <= '0;
            c_q     <= '0;
            i_q     <= '0;
            j_q     <= DW'(1);
            state_q <= ST_PAIRS;
          end
        end
        ST_PAIRS, ST_OUTP: begin
          if (state_q == ST_OUTP && conn && !sub_q) begin
            sub_q <= 1'b1;
          end else begin
            sub_q <= 1'b0;
            if (conn) c_q <= c_q + 5'd1;
            bit_q <= bit_q + 5'd1;
            if (j_q == LAST_DIM) begin
              i_q <= i_q + DW'(1);
              j_q <= i_q + DW'(2);
            end else begin
              j_q <= j_q + DW'(1);
            end
            if (bit_q == 5'(NP - 1))
              state_q <= (state_q == ST_PAIRS) ? ST_DRAIN : ST_ODRN;
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) state_q <= ST_FIN;
        end
        ST_FIN: begin
          state_q <= ST_SIG;
        end
        ST_SIG: begin
          kind_q      <= 1'b0;
          index_q     <= 5'(d_q);
          prob_q      <= crfpl_pkg::sigmoid_fx(z_q);
          pfirst_q    <= '0;
          psecond_q   <= '0;
          last_q      <= ((DW+1)'(d_q) == nd - 1'b1) && !any_pair;
          if ((DW+1)'(d_q) == nd - 1'b1) begin
            bit_q   <= '0;
            c_q     <= '0;
            i_q     <= '0;
            j_q     <= DW'(1);
            sub_q   <= 1'b0;
            state_q <= ST_OUTP;
          end else begin
            d_q     <= d_q + DW'(1);
            f_q     <= '0;
            state_q <= ST_FEAT;
          end
        end
        ST_ODRN: begin
          if (!v1_q && !v2_q) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase

      // Drain the product stage
      if (mac_v && tag2_q == TAG_PS) begin
        kind_q      <= 1'b1;
        index_q     <= idx2_q;
        prob_q      <= '0;
        pfirst_q    <= pf_q;
        psecond_q   <= prod[FRAC_HI:crfpl_pkg::FRAC_BITS];
        last_q      <= last2_q;
      end
    end
  end

  // Accumulate z, hold the first pair product and saturate z
  always_ff @(posedge clk_i) begin
    if (accept && operation_i == crfpl_pkg::OP_COMPUTE) begin
      acc_q <= AW'(bias_q[0]);
    end else if (state_q == ST_SIG && (DW+1)'(d_q) != nd - 1'b1) begin
      acc_q <= AW'(bias_q[d_q + DW'(1)]);
    end else if (mac_v && (tag2_q == TAG_FEAT || tag2_q == TAG_PW)) begin
      acc_q <= acc_q + AW'(prod >>> crfpl_pkg::FRAC_BITS);
    end
    if (mac_v && tag2_q == TAG_PF) pf_q <= prod[FRAC_HI:crfpl_pkg::FRAC_BITS];
    if (state_q == ST_FIN) begin
      if (zsum > AW'(24'sh7FFFFF)) z_q <= 24'sh7FFFFF;
      else if (zsum < -AW'(40'sh800000)) z_q <= -24'sh800000;
      else z_q <= zsum[VW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign index_o       = index_q;
  assign probability_o = prob_q;
  assign pair_first_o  = pfirst_q;
  assign pair_second_o = psecond_q;
  assign last_o        = last_q;

endmodule

/* tb/crf_pseudolikelihood_marginals_tb.sv */
`timescale 1ns / 1ps

module crf_pseudolikelihood_marginals_tb;

  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    logic [16:0] prob;
    logic [16:0] pfirst;
    logic [16:0] psecond;
    logic        last;
  } crf_result_t;

  // Features loaded; no compute uses more than these
  localparam int unsigned NF_LOADED = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [27:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  operation_i = '0;
  logic [5:0]  index_a_i = '0;
  logic [2:0]  index_b_i = '0;
  logic signed [crfpl_pkg::VAL_W-1:0] value_i = '0;
  logic [2:0]  category_i = '0;
  logic        out_valid_o, kind_o, last_o;
  logic [4:0]  index_o;
  logic [crfpl_pkg::PROB_W-1:0] probability_o, pair_first_o, pair_second_o;

  crf_pseudolikelihood_marginals uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .operation_i, .index_a_i, .index_b_i, .value_i, .category_i,
    .out_valid_o, .kind_o, .index_o, .probability_o, .pair_first_o,
    .pair_second_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block's configuration and stores
  int unsigned  m_dims, m_feats, m_mask, m_emis;
  longint       m_bias[8], m_fw[64][8], m_pw[28], m_oem[8][4], m_iem[8][4];
  longint       m_feat[64], m_post[8], m_marg[8];
  int unsigned  m_lvl[8];

  crf_result_t  marginal_q[$];
  int           errors = 0;
  int           n_words = 0, n_computes = 0, n_results = 0;
  int           gap_pct = 0;

  function automatic longint sigmoid_q16(longint z);
    longint a, y;
    a = (z < 0) ? -z : z;
    if (a >= 327680) y = 65536;
    else if (a >= 155648) y = (a >> 5) + 55296;
    else if (a >= 65536) y = (a >> 3) + 40960;
    else y = (a >> 2) + 32768;
    if (y > 65536) y = 65536;
    return (z < 0) ? 65536 - y : y;
  endfunction

  // Work out the marginals and pair words of one compute
  task automatic predict_marginals();
    int unsigned nd, nf, bitn, c;
    longint z;
    crf_result_t r;
    nd = (m_dims == 0) ? 1 : (m_dims > 8 ? 8 : m_dims);
    nf = (m_feats > 64) ? 64 : m_feats;
    for (int d = 0; d < nd; d++) begin
      z = m_bias[d];
      for (int f = 0; f < nf; f++) z += (m_feat[f] * m_fw[f][d]) >>> 16;
      bitn = 0;
      c = 0;
      for (int i = 0; i < 8; i++) begin
        for (int j = i + 1; j < 8; j++) begin
          if (j < nd && m_mask[bitn]) begin
            if (i == d) z += (m_pw[c] * m_post[j]) >>> 16;
            else if (j == d) z += (m_pw[c] * m_post[i]) >>> 16;
            c++;
          end
          bitn++;
        end
      end
      if (m_emis != 0 && m_lvl[d] >= 1 && m_lvl[d] <= 4)
        z += m_oem[d][m_lvl[d]-1] - m_iem[d][m_lvl[d]-1];
      if (z > 64'sh7FFFFF) z = 64'sh7FFFFF;
      if (z < -64'sh800000) z = -64'sh800000;
      m_marg[d] = sigmoid_q16(z);
      r = '0;
      r.idx = 5'(d);
      r.prob = 17'(m_marg[d]);
      marginal_q.push_back(r);
    end
    bitn = 0;
    c = 0;
    for (int i = 0; i < 8; i++) begin
      for (int j = i + 1; j < 8; j++) begin
        if (j < nd && m_mask[bitn]) begin
          r = '0;
          r.kind = 1'b1;
          r.idx = 5'(c);
          r.pfirst = 17'((m_marg[i] * m_post[j]) >> 16);
          r.psecond = 17'((m_post[i] * m_marg[j]) >> 16);
          marginal_q.push_back(r);
          c++;
        end
        bitn++;
      end
    end
    r = marginal_q.pop_back();
    r.last = 1'b1;
    marginal_q.push_back(r);
  endtask

  task automatic apply_word(crfpl_pkg::op_e op, int unsigned ia, int unsigned ib, longint v,
                            int unsigned cat);
    case (op)
      crfpl_pkg::OP_BIAS:    if (ia < 8) m_bias[ia] = v;
      crfpl_pkg::OP_FWEIGHT: m_fw[ia][ib] = v;
      crfpl_pkg::OP_PWEIGHT: if (ia < 28) m_pw[ia] = v;
      crfpl_pkg::OP_OEMIS:   if (ia < 8 && ib >= 1 && ib <= 4) m_oem[ia][ib-1] = v;
      crfpl_pkg::OP_IEMIS:   if (ia < 8 && ib >= 1 && ib <= 4) m_iem[ia][ib-1] = v;
      crfpl_pkg::OP_FEATURE: m_feat[ia] = v;
      crfpl_pkg::OP_POST: begin
        if (ia < 8) begin
          m_post[ia] = (v < 0) ? 0 : (v > 65536 ? 65536 : v);
          m_lvl[ia] = (cat >= 1 && cat <= 4) ? cat : 0;
        end
      end
      default: begin
        n_computes++;
        predict_marginals();
      end
    endcase
  endtask

  // Send one word; called and returns at a falling edge
  task automatic send_word(crfpl_pkg::op_e op, int unsigned ia, int unsigned ib, longint v,
                           int unsigned cat);
    operation_i = op;
    index_a_i = 6'(ia);
    index_b_i = 3'(ib);
    value_i = 24'(v);
    category_i = 3'(cat);
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    apply_word(op, ia & 63, ib & 7, longint'(value_i), cat & 7);
    n_words++;
    @(negedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (marginal_q.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(crfpl_pkg::cfg_e idx, int unsigned data);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = 28'(data);
    case (idx)
      crfpl_pkg::CFG_NUM_DIMS:     m_dims = data & 32'hF;
      crfpl_pkg::CFG_NUM_FEATURES: m_feats = data & 32'h7F;
      crfpl_pkg::CFG_EDGE_MASK:    m_mask = data & 32'hFFFFFFF;
      default:                     m_emis = data & 1;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic longint rand_value();
    case ($urandom_range(9))
      0:       return longint'($signed(24'($urandom)));
      1:       return $urandom_range(1) ? 64'sh7FFFFF : -64'sh800000;
      default: return longint'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic longint rand_post();
    case ($urandom_range(9))
      0:       return longint'($signed(24'($urandom)));
      1:       return $urandom_range(1) ? 65536 : 0;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    crf_result_t got, want;
    if (rst_ni && out_valid_o) begin
      got = {kind_o, index_o, probability_o, pair_first_o, pair_second_o, last_o};
      n_results++;
      if (marginal_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d index=%0d prob=%0d pf=%0d ps=%0d last=%0d",
                 $time, got.kind, got.idx, got.prob, got.pfirst, got.psecond, got.last);
        errors++;
      end else begin
        want = marginal_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected kind=%0d index=%0d prob=%0d pf=%0d ps=%0d last=%0d",
                   $time, want.kind, want.idx, want.prob, want.pfirst, want.psecond,
                   want.last);
          $display("%0t:          actual   kind=%0d index=%0d prob=%0d pf=%0d ps=%0d last=%0d",
                   $time, got.kind, got.idx, got.prob, got.pfirst, got.psecond, got.last);
          errors++;
        end
      end
    end
  end

  // Fill every store that a compute reads, with the feature count kept small
  task automatic test_load_all();
    write_reg(crfpl_pkg::CFG_NUM_FEATURES, NF_LOADED);
    for (int d = 0; d < 8; d++) send_word(crfpl_pkg::OP_BIAS, d, 0, rand_value(), 0);
    for (int f = 0; f < NF_LOADED; f++) begin
      send_word(crfpl_pkg::OP_FEATURE, f, 0, rand_value(), 0);
      for (int d = 0; d < 8; d++)
        send_word(crfpl_pkg::OP_FWEIGHT, f, d, rand_value() >>> 4, 0);
    end
    for (int c = 0; c < 28; c++) send_word(crfpl_pkg::OP_PWEIGHT, c, 0, rand_value(), 0);
    for (int d = 0; d < 8; d++) begin
      for (int l = 1; l <= 4; l++) begin
        send_word(crfpl_pkg::OP_OEMIS, d, l, rand_value(), 0);
        send_word(crfpl_pkg::OP_IEMIS, d, l, rand_value(), 0);
      end
      send_word(crfpl_pkg::OP_POST, d, 0, rand_post(), $urandom_range(0, 4));
    end
    send_word(crfpl_pkg::OP_COMPUTE, 0, 0, 0, 0);
  endtask

  // Extremes, ignored loads and saturation cases
  task automatic test_directed();
    send_word(crfpl_pkg::OP_BIAS, 0, 0, 64'sh7FFFFF, 0);
    send_word(crfpl_pkg::OP_BIAS, 1, 0, -64'sh800000, 0);
    send_word(crfpl_pkg::OP_BIAS, 8, 0, 12345, 0);
    send_word(crfpl_pkg::OP_BIAS, 63, 7, -1, 7);
    send_word(crfpl_pkg::OP_PWEIGHT, 28, 0, 777, 0);
    send_word(crfpl_pkg::OP_PWEIGHT, 27, 0, -64'sh800000, 0);
    send_word(crfpl_pkg::OP_OEMIS, 2, 0, 999, 0);
    send_word(crfpl_pkg::OP_IEMIS, 2, 5, 999, 0);
    send_word(crfpl_pkg::OP_OEMIS, 9, 1, 999, 0);
    send_word(crfpl_pkg::OP_IEMIS, 3, 4, 64'sh7FFFFF, 0);
    send_word(crfpl_pkg::OP_POST, 2, 0, -5, 0);
    send_word(crfpl_pkg::OP_POST, 3, 0, 64'sh7FFFFF, 5);
    send_word(crfpl_pkg::OP_POST, 4, 0, 65536, 4);
    send_word(crfpl_pkg::OP_POST, 5, 0, 0, 7);
    send_word(crfpl_pkg::OP_POST, 6, 0, 32768, 1);
    send_word(crfpl_pkg::OP_POST, 12, 0, 1, 1);
    send_word(crfpl_pkg::OP_FEATURE, 63, 0, 64'sh7FFFFF, 0);
    send_word(crfpl_pkg::OP_FWEIGHT, 63, 7, -64'sh800000, 0);
    send_word(crfpl_pkg::OP_FEATURE, 0, 0, 0, 0);
    send_word(crfpl_pkg::OP_COMPUTE, 63, 7, -1, 7);
  endtask

  // Sweep the registers through their extremes, one compute per setting
  task automatic test_config_sweep();
    int unsigned dims[5] = '{0, 1, 2, 8, 15};
    int unsigned feats[5] = '{0, 4, 1, 3, 2};
    int unsigned masks[5] = '{0, 32'hFFFFFFF, 32'h5555555, 32'hAAAAAAA, 32'hFFFFFFF};
    for (int k = 0; k < 5; k++) begin
      write_reg(crfpl_pkg::CFG_NUM_DIMS, dims[k]);
      write_reg(crfpl_pkg::CFG_NUM_FEATURES, feats[k]);
      write_reg(crfpl_pkg::CFG_EDGE_MASK, masks[k]);
      write_reg(crfpl_pkg::CFG_USE_EMISSION, k % 2);
      send_word(crfpl_pkg::OP_COMPUTE, 0, 0, 0, 0);
    end
  endtask

  // Samples with random content, mixed with stray loads
  task automatic test_random(int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 2) begin
        send_word(crfpl_pkg::op_e'($urandom_range(0, 6)), $urandom_range(0, 63),
                  $urandom_range(0, 7), longint'($signed(24'($urandom))),
                  $urandom_range(0, 7));
        sent++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(crfpl_pkg::OP_FEATURE, $urandom_range(0, 3), 0, rand_value(), 0);
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          send_word(crfpl_pkg::OP_POST, $urandom_range(0, 7), 0, rand_post(),
                    $urandom_range(0, 7));
          sent++;
        end
        if ($urandom_range(1)) begin
          send_word(crfpl_pkg::op_e'($urandom_range(0, 4)), $urandom_range(0, 27),
                    $urandom_range(0, 7), rand_value(), 0);
          sent++;
        end
        send_word(crfpl_pkg::OP_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 7), 0, 0);
        sent++;
      end
    end
  endtask

  task automatic random_setting();
    write_reg(crfpl_pkg::CFG_NUM_DIMS, $urandom_range(0, 15));
    write_reg(crfpl_pkg::CFG_NUM_FEATURES, $urandom_range(0, NF_LOADED));
    write_reg(crfpl_pkg::CFG_EDGE_MASK, $urandom & 32'hFFFFFFF);
    write_reg(crfpl_pkg::CFG_USE_EMISSION, $urandom_range(1));
  endtask

  initial begin
    m_dims = 8;
    m_feats = 64;
    m_mask = 32'hFFFFFFF;
    m_emis = 1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_load_all();
    test_directed();
    test_config_sweep();
    gap_pct = 0;
    random_setting();
    test_random(5);
    gap_pct = 62;
    random_setting();
    test_random(5);
    gap_pct = 30;
    random_setting();
    test_random(5);
    gap_pct = 0;
    random_setting();
    test_random(5);

    wait_idle();
    repeat (50) @(negedge clk_i);
    if (marginal_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, marginal_q.size());
      errors++;
    end
    $display("Ran %0d words including %0d computes; checked %0d result words, %0d errors.",
             n_words, n_computes, n_results, errors);
    if (errors == 0) begin
      $display("** crf_pseudolikelihood_marginals: PASSED **");
    end else begin
      $display("** crf_pseudolikelihood_marginals: FAILED **");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #4ms;
    $display("%0t: timeout", $time);
    $display("** crf_pseudolikelihood_marginals: FAILED **");
    $finish;
  end

endmodule
